// ===== hw/rtl/ksbe_pkg.sv =====
package ksbe_pkg;

	// pool and field widths
	localparam int POOL_MAX   = 16;
	localparam int POOL_IDX_W = $clog2(POOL_MAX);
	localparam int POP_BITS   = 10;
	localparam int SIZE_W     = 5;
	localparam int MODEL_W    = 16;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_NEXT    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SOURCES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SOURCES = 2'd2;

	// register reset values
	localparam logic [SIZE_W-1:0] POOL_SIZE_RST   = 5'd16;
	localparam logic [SIZE_W-1:0] MIN_SOURCES_RST = 5'd1;
	localparam logic [SIZE_W-1:0] MAX_SOURCES_RST = 5'd16;

	// controller to datapath
	typedef struct packed {
		logic pool_we;
		logic rewind;
		logic start;
		logic issue;
		logic load_member;
		logic load_exh;
		logic advance;
	} ksbe_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
		logic all_issued;
		logic s1_valid;
		logic s1_last;
		logic slot_free;
	} ksbe_stat_t;

endpackage

// ===== hw/rtl/ksbe_ram.sv =====
module ksbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/ksbe_ctrl.sv =====
module ksbe_ctrl import ksbe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [REQ_W-1:0] req_type,
	output logic             in_ready,
	input  ksbe_stat_t       stat,
	output ksbe_cmd_t        cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EMIT = 2'd1;
	localparam logic [1:0] ST_EXH  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       load;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		load     = stat.s1_valid && stat.slot_free;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (req_type)
						REQ_LOAD: begin
							cmd.pool_we = 1'b1;
						end
						REQ_NEXT: begin
							if (stat.done) begin
								state_d = ST_EXH;
							end else begin
								cmd.start = 1'b1;
								state_d   = ST_EMIT;
							end
						end
						REQ_RESTART: begin
							cmd.rewind = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_EMIT: begin
				// one member read per cycle, held while the output beat stalls
				cmd.load_member = load;
				cmd.issue       = (!stat.s1_valid || load) && !stat.all_issued;
				if (load && stat.s1_last) begin
					cmd.advance = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_EXH: begin
				if (stat.slot_free) begin
					cmd.load_exh = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/ksbe_dp.sv =====
module ksbe_dp import ksbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ksbe_cmd_t             cmd,
	output ksbe_stat_t            stat,
	input  logic [POOL_IDX_W-1:0] slot,
	input  logic [POP_BITS-1:0]   population,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POP_BITS-1:0]   member_population,
	output logic [MODEL_W-1:0]    model_number,
	output logic                  last_of_model,
	output logic                  exhausted
);

	logic [SIZE_W-1:0]     pool_size_q, min_src_q, max_src_q;
	logic [SIZE_W-1:0]     pool_nx, min_nx, max_nx;
	logic [SIZE_W-1:0]     n_nx, top_nx, lo_nx, n_cur, top_cur, size_inc;
	logic                  cfg_hit, rewind;

	logic [POOL_IDX_W-1:0] combo_q [POOL_MAX];
	logic [POOL_IDX_W-1:0] combo_fill [POOL_MAX];
	logic [SIZE_W-1:0]     size_q;
	logic [MODEL_W-1:0]    counter_q;
	logic                  done_q;

	logic [SIZE_W-1:0]     idx_q;
	logic [POOL_IDX_W-1:0] rd_pos, pivot_q;
	logic                  found_q;
	logic [SIZE_W-1:0]     pos_limit;
	logic                  s1_valid_s1, s1_last_s1;
	logic [POP_BITS-1:0]   ram_rdata;

	logic                  out_valid_q;

	// register values as they stand after this edge's write
	always_comb begin
		pool_nx = pool_size_q;
		min_nx  = min_src_q;
		max_nx  = max_src_q;
		cfg_hit = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				CFG_POOL_SIZE: begin
					pool_nx = cfg_data;
					cfg_hit = 1'b1;
				end
				CFG_MIN_SOURCES: begin
					min_nx  = cfg_data;
					cfg_hit = 1'b1;
				end
				CFG_MAX_SOURCES: begin
					max_nx  = cfg_data;
					cfg_hit = 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign rewind   = cfg_hit || cmd.rewind;
	assign n_nx     = (pool_nx > SIZE_W'(POOL_MAX)) ? SIZE_W'(POOL_MAX) : pool_nx;
	assign top_nx   = (max_nx < n_nx) ? max_nx : n_nx;
	assign lo_nx    = (min_nx == '0) ? SIZE_W'(1) : min_nx;
	assign n_cur    = (pool_size_q > SIZE_W'(POOL_MAX)) ? SIZE_W'(POOL_MAX) : pool_size_q;
	assign top_cur  = (max_src_q < n_cur) ? max_src_q : n_cur;
	assign size_inc = size_q + SIZE_W'(1);

	// position of the member being read and the highest value it may take
	assign rd_pos    = combo_q[idx_q[POOL_IDX_W-1:0]];
	assign pos_limit = n_cur - size_q + idx_q;

	// successor combination: bump the pivot, then consecutive positions after it
	always_comb begin
		for (int j = 0; j < POOL_MAX; j++) begin
			if (POOL_IDX_W'(j) >= pivot_q) begin
				combo_fill[j] = combo_q[pivot_q] + POOL_IDX_W'(1)
					+ (POOL_IDX_W'(j) - pivot_q);
			end else begin
				combo_fill[j] = combo_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_size_q <= POOL_SIZE_RST;
			min_src_q   <= MIN_SOURCES_RST;
			max_src_q   <= MAX_SOURCES_RST;
			size_q      <= MIN_SOURCES_RST;
			counter_q   <= '0;
			done_q      <= 1'b0;
			for (int i = 0; i < POOL_MAX; i++) begin
				combo_q[i] <= POOL_IDX_W'(i);
			end
		end else begin
			pool_size_q <= pool_nx;
			min_src_q   <= min_nx;
			max_src_q   <= max_nx;
			if (rewind) begin
				counter_q <= '0;
				if (lo_nx > top_nx) begin
					done_q <= 1'b1;
					size_q <= '0;
				end else begin
					done_q <= 1'b0;
					size_q <= lo_nx;
				end
				for (int i = 0; i < POOL_MAX; i++) begin
					combo_q[i] <= POOL_IDX_W'(i);
				end
			end else if (cmd.advance) begin
				counter_q <= counter_q + MODEL_W'(1);
				if (found_q) begin
					combo_q <= combo_fill;
				end else if (size_inc > top_cur) begin
					done_q <= 1'b1;
				end else begin
					size_q <= size_inc;
					for (int i = 0; i < POOL_MAX; i++) begin
						combo_q[i] <= POOL_IDX_W'(i);
					end
				end
			end
		end
	end

	// member read sequencing; the pivot is the last position below its limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			found_q     <= 1'b0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + SIZE_W'(1);
				if ({1'b0, rd_pos} != pos_limit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.issue) begin
				s1_valid_s1 <= 1'b1;
			end else if (cmd.load_member) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			s1_last_s1 <= (idx_q + SIZE_W'(1)) == size_q;
			if ({1'b0, rd_pos} != pos_limit) begin
				pivot_q <= idx_q[POOL_IDX_W-1:0];
			end
		end
	end

	ksbe_ram #(
		.WIDTH (POP_BITS),
		.DEPTH (POOL_MAX)
	) u_pool (
		.clk   (clk),
		.we    (cmd.pool_we),
		.waddr (slot),
		.wdata (population),
		.re    (cmd.issue),
		.raddr (rd_pos),
		.rdata (ram_rdata)
	);

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_member || cmd.load_exh) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_member) begin
			member_population <= ram_rdata;
			model_number      <= counter_q;
			last_of_model     <= s1_last_s1;
			exhausted         <= 1'b0;
		end else if (cmd.load_exh) begin
			member_population <= '0;
			model_number      <= counter_q;
			last_of_model     <= 1'b1;
			exhausted         <= 1'b1;
		end
	end

	assign out_valid       = out_valid_q;
	assign stat.done       = done_q;
	assign stat.all_issued = (idx_q == size_q);
	assign stat.s1_valid   = s1_valid_s1;
	assign stat.s1_last    = s1_last_s1;
	assign stat.slot_free  = !out_valid_q || out_ready;

endmodule

// ===== hw/rtl/k_subset_band_enumerator_core.sv =====
// next beat of a k-member subset: the first member passes the pool memory read
// register, then the output beat register; then one member per cycle (the pool
// memory gives one read per cycle) unless the output stalls; ready returns when
// the last member or the exhausted beat is loaded; load and restart keep ready high
// reset: pool_size 16, band 1..16, first subset {slot 0}, model number zero;
// pool contents are not cleared and must be loaded before use
module k_subset_band_enumerator_core import ksbe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [POOL_IDX_W-1:0] slot,
	input  logic [POP_BITS-1:0]   population,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [POP_BITS-1:0]   member_population,
	output logic [MODEL_W-1:0]    model_number,
	output logic                  last_of_model,
	output logic                  exhausted,
	// register writes
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// command and status between the sequencer and the datapath
	ksbe_cmd_t  cmd;
	ksbe_stat_t stat;

	// sequencer: takes request beats while idle, then steps the member reads
	// of one subset, or sends the single exhausted beat
	ksbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: band registers, combination positions, pool memory, the
	// read stage and the output beat register; the successor combination is
	// formed from the pivot found while the members are read out
	ksbe_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.slot              (slot),
		.population        (population),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.member_population (member_population),
		.model_number      (model_number),
		.last_of_model     (last_of_model),
		.exhausted         (exhausted)
	);

endmodule

// ===== hw/rtl/ksbe_chk.sv =====
module ksbe_chk import ksbe_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [REQ_W-1:0]      req_type,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [POP_BITS-1:0]   member_population,
	input logic [MODEL_W-1:0]    model_number,
	input logic                  last_of_model,
	input logic                  exhausted
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(model_number)
			&& $stable(member_population) && $stable(last_of_model))
		else $error("result beat changed while stalled");

	// exhausted beat is a closing beat with no member
	a_exh_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exhausted |-> last_of_model && member_population == '0)
		else $error("malformed exhausted beat");

	// a next beat leaves the block busy in the cycle after it is taken
	a_next_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == REQ_NEXT |=> !in_ready)
		else $error("ready high straight after a next beat");

	// load, restart and unknown beats leave the block ready in the cycle after
	a_other_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type != REQ_NEXT |=> in_ready)
		else $error("ready dropped after a single cycle beat");

endmodule

bind k_subset_band_enumerator_core ksbe_chk u_ksbe_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.req_type          (req_type),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.member_population (member_population),
	.model_number      (model_number),
	.last_of_model     (last_of_model),
	.exhausted         (exhausted)
);

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ksbe_pkg::*;

	// codes the package leaves unnamed: the spare request and the spare register index
	localparam logic [REQ_W-1:0]     REQ_IGNORED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

	localparam int PLAN_ROWS    = 25;
	localparam int RANDOM_BEATS = 70;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int REPORT_MAX   = 10;

	// one member beat on the result channel
	typedef struct packed {
		logic [POP_BITS-1:0] member;
		logic [MODEL_W-1:0]  model;
		logic                last;
		logic                exh;
	} subset_member_t;

	// one row of the directed plan: either a request beat or a register write
	typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [REQ_W-1:0]       req;
		logic [POOL_IDX_W-1:0]  slot;
		logic [POP_BITS-1:0]    pop;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  reg_val;
		logic                   typed;
		subset_member_t         want;
	} row_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic [REQ_W-1:0]      req_type   = REQ_LOAD;
	logic [POOL_IDX_W-1:0] slot       = '0;
	logic [POP_BITS-1:0]   population = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [POP_BITS-1:0]   member_population;
	logic [MODEL_W-1:0]    model_number;
	logic                  last_of_model;
	logic                  exhausted;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	k_subset_band_enumerator_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.req_type          (req_type),
		.slot              (slot),
		.population        (population),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.member_population (member_population),
		.model_number      (model_number),
		.last_of_model     (last_of_model),
		.exhausted         (exhausted),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// subset enumerator shadow: registers, pool copy and walk position
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0]   shadow_pool_size;
	logic [SIZE_W-1:0]   shadow_min;
	logic [SIZE_W-1:0]   shadow_max;
	logic [POP_BITS-1:0] pool_copy [POOL_MAX];
	int                  positions [POOL_MAX];
	int                  subset_size;
	logic [MODEL_W-1:0]  subset_count;
	bit                  band_done;

	// members still owed by the block, oldest first
	subset_member_t expected_members [$];

	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  calm           = 1'b0;
	int  stall_left     = 0;

	// a pool size beyond the pool maximum folds onto it
	function automatic int usable_pool();
		return (int'(shadow_pool_size) > POOL_MAX) ? POOL_MAX : int'(shadow_pool_size);
	endfunction

	function automatic int band_top();
		int n;
		n = usable_pool();
		return (int'(shadow_max) < n) ? int'(shadow_max) : n;
	endfunction

	function automatic void first_subset(int k);
		for (int i = 0; i < POOL_MAX; i++)
			positions[i] = (i < k) ? i : 0;
	endfunction

	// back to the first subset of the smallest valid size; a size of zero counts as one
	function automatic void rewind_band();
		int k;
		k = (shadow_min < 1) ? 1 : int'(shadow_min);
		subset_count = '0;
		if (k > band_top()) begin
			band_done   = 1'b1;
			subset_size = 0;
			first_subset(0);
		end else begin
			band_done   = 1'b0;
			subset_size = k;
			first_subset(k);
		end
	endfunction

	// lexicographic successor; once the size is used up, move to the next size
	function automatic void advance_subset();
		int n;
		int k;
		int i;
		n = usable_pool();
		k = subset_size;
		i = k - 1;
		while (i >= 0 && positions[i] == n - k + i)
			i--;
		if (i >= 0) begin
			positions[i]++;
			for (int j = i + 1; j < k; j++)
				positions[j] = positions[j - 1] + 1;
			return;
		end
		k++;
		if (k > band_top()) begin
			band_done = 1'b1;
			return;
		end
		subset_size = k;
		first_subset(k);
	endfunction

	// the spare index changes nothing, not even the walk position
	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_POOL_SIZE:   shadow_pool_size = val;
			CFG_MIN_SOURCES: shadow_min       = val;
			CFG_MAX_SOURCES: shadow_max       = val;
			default:         return;
		endcase
		rewind_band();
	endfunction

	// append one owed member beat
	function automatic void owe_member(subset_member_t m);
		expected_members = {expected_members, m};
	endfunction

	function automatic void enumerate_request(logic [REQ_W-1:0] req,
			logic [POOL_IDX_W-1:0] s, logic [POP_BITS-1:0] p);
		subset_member_t m;
		case (req)
			REQ_LOAD:    pool_copy[s] = p;
			REQ_RESTART: rewind_band();
			REQ_NEXT: begin
				if (band_done) begin
					m.member = '0;
					m.model  = subset_count;
					m.last   = 1'b1;
					m.exh    = 1'b1;
					owe_member(m);
				end else begin
					for (int i = 0; i < subset_size; i++) begin
						m.member = pool_copy[positions[i]];
						m.model  = subset_count;
						m.last   = (i == subset_size - 1);
						m.exh    = 1'b0;
						owe_member(m);
					end
					subset_count = subset_count + MODEL_W'(1);
					advance_subset();
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// idling: mostly none, sometimes a short one, now and then a long gap
	// ------------------------------------------------------------------
	function automatic int gap_len();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// mostly a small band, sometimes anything the 5-bit register holds
	function automatic logic [CFG_DATA_W-1:0] pick_reg(int lo, int hi);
		if ($urandom_range(0, 99) < 85)
			return CFG_DATA_W'($urandom_range(lo, hi));
		return CFG_DATA_W'($urandom_range(0, 31));
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	task automatic send_beat(input logic [REQ_W-1:0] req, input logic [POOL_IDX_W-1:0] s,
			input logic [POP_BITS-1:0] p, input logic typed, input subset_member_t want);
		int gap;
		int depth;
		gap = gap_len();
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		req_type   <= req;
		slot       <= s;
		population <= p;
		do @(posedge clk); while (!in_ready);
		// beat accepted: the shadow moves on, typed rows replace what it predicted
		depth = expected_members.size();
		enumerate_request(req, s, p);
		if (typed) begin
			while (expected_members.size() > depth)
				void'(expected_members.pop_back());
			owe_member(want);
		end
	endtask

	// hold off requests until the block owes nothing, then let it settle
	task automatic drain_results(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_members.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// register writes only land on an idle block
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		drain_results(8);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_register(idx, val);
	endtask

	function automatic row_t beat_row(logic [REQ_W-1:0] req, logic [POOL_IDX_W-1:0] s,
			logic [POP_BITS-1:0] p);
		row_t r;
		r      = '0;
		r.kind = ROW_BEAT;
		r.req  = req;
		r.slot = s;
		r.pop  = p;
		return r;
	endfunction

	function automatic row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		row_t r;
		r         = '0;
		r.kind    = ROW_REG;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	// a next beat whose single answer is plain to see
	function automatic row_t next_row(logic [POP_BITS-1:0] member, logic [MODEL_W-1:0] model,
			logic exh);
		row_t r;
		r             = beat_row(REQ_NEXT, '0, '0);
		r.typed       = 1'b1;
		r.want.member = member;
		r.want.model  = model;
		r.want.last   = 1'b1;
		r.want.exh    = exh;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result side: random stalls, and each member beat against the oldest owed one
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_left == 0)
			stall_left = gap_len() + 1;
		out_ready <= (stall_left == 1);
		stall_left = stall_left - 1;
	end

	always @(posedge clk) begin
		subset_member_t got;
		subset_member_t want;
		if (arst_n && out_valid && out_ready) begin
			got.member = member_population;
			got.model  = model_number;
			got.last   = last_of_model;
			got.exh    = exhausted;
			if (expected_members.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected member beat: pop %0d model %0d last %0b exh %0b",
						got.member, got.model, got.last, got.exh);
			end else begin
				want = expected_members.pop_front();
				if (got.member !== want.member || got.model !== want.model ||
						got.last !== want.last || got.exh !== want.exh) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("member beat mismatch: got %0d/%0d/%0b/%0b want %0d/%0d/%0b/%0b",
							got.member, got.model, got.last, got.exh,
							want.member, want.model, want.last, want.exh);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		row_t           plan [PLAN_ROWS];
		subset_member_t none;
		int             random_beats;
		int             burst;
		int             roll;
		logic [REQ_W-1:0] req;

		none = '0;

		// reset state: pool of 16, band 1..16, first subset is slot 0 alone
		shadow_pool_size = POOL_SIZE_RST;
		shadow_min       = MIN_SOURCES_RST;
		shadow_max       = MAX_SOURCES_RST;
		rewind_band();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// the pool is not cleared by reset, so every slot is filled before any next beat
		for (int s = 0; s < POOL_MAX; s++)
			send_beat(REQ_LOAD, POOL_IDX_W'(s), POP_BITS'($urandom_range(0, 1023)), 1'b0, none);

		plan = '{
			beat_row(REQ_LOAD, 4'd0, 10'd1023),        // extremes of slot and population
			beat_row(REQ_LOAD, 4'd15, 10'd0),
			next_row(10'd1023, 16'd0, 1'b0),            // first subset after reset
			beat_row(REQ_NEXT, 4'd0, 10'd0),
			beat_row(REQ_IGNORED, 4'd15, 10'd1023),    // spare request code gives nothing
			beat_row(REQ_RESTART, 4'd0, 10'd0),
			next_row(10'd1023, 16'd0, 1'b0),            // restart rewound the count
			reg_row(CFG_POOL_SIZE, 5'd0),               // empty pool empties the band
			next_row(10'd0, 16'd0, 1'b1),
			reg_row(CFG_POOL_SIZE, 5'd31),              // oversized pool folds to 16
			reg_row(CFG_MIN_SOURCES, 5'd16),
			beat_row(REQ_NEXT, 4'd0, 10'd0),            // the one 16-member subset
			next_row(10'd0, 16'd1, 1'b1),
			reg_row(CFG_MIN_SOURCES, 5'd0),             // zero minimum counts as one
			reg_row(CFG_MAX_SOURCES, 5'd1),
			reg_row(CFG_POOL_SIZE, 5'd1),
			next_row(10'd1023, 16'd0, 1'b0),
			next_row(10'd0, 16'd1, 1'b1),
			reg_row(CFG_SPARE, 5'd31),                  // spare index must not rewind
			next_row(10'd0, 16'd1, 1'b1),
			reg_row(CFG_MAX_SOURCES, 5'd0),             // zero maximum empties the band
			next_row(10'd0, 16'd0, 1'b1),
			reg_row(CFG_MAX_SOURCES, 5'd31),
			reg_row(CFG_POOL_SIZE, 5'd16),
			next_row(10'd1023, 16'd0, 1'b0)
		};

		for (int r = 0; r < PLAN_ROWS; r++) begin
			if (plan[r].kind == ROW_REG)
				write_reg(plan[r].reg_idx, plan[r].reg_val);
			else
				send_beat(plan[r].req, plan[r].slot, plan[r].pop, plan[r].typed, plan[r].want);
		end

		// random phases: band registers rewritten at random, then a burst that walks well into the band
		random_beats = 0;
		while (random_beats < RANDOM_BEATS) begin
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_POOL_SIZE, pick_reg(1, 6));
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_MIN_SOURCES, pick_reg(0, 4));
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_MAX_SOURCES, pick_reg(1, 6));
			if ($urandom_range(0, 9) == 0)
				write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 31)));
			burst = $urandom_range(8, 20);
			repeat (burst) begin
				if ($urandom_range(0, 99) < 5)
					drain_results(0);
				roll = $urandom_range(0, 99);
				if (roll < 75)
					req = REQ_NEXT;
				else if (roll < 87)
					req = REQ_LOAD;
				else if (roll < 95)
					req = REQ_RESTART;
				else
					req = REQ_IGNORED;
				send_beat(req, POOL_IDX_W'($urandom_range(0, 15)),
					POP_BITS'($urandom_range(0, 1023)), 1'b0, none);
				if (req != REQ_IGNORED)
					random_beats++;
			end
		end

		// wind down: nothing owed, then a short settle for stray beats
		drain_results(20);
		if (expected_members.size() != 0) begin
			mismatch_count += expected_members.size();
			$display("%0d member beats never arrived", expected_members.size());
		end

		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
